### rtl/core/slcan_pkg.sv
// Shared types and constants for the SLCAN ASCII frame parser.
// Holds the character class record, the result record and the result kinds.
// No dependencies.
`timescale 1ns / 1ps

package slcan_pkg;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_BELL = 8'h07;
    localparam int STD_ID_DIGITS = 3;
    localparam int EXT_ID_DIGITS = 8;
    localparam logic [3:0] MAX_LEN = 4'd8;
    localparam logic [3:0] BAD_LEN = 4'd15;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] KIND_FRAME = 3'd0;
    localparam logic [2:0] KIND_BELL = 3'd1;
    localparam logic [2:0] KIND_UNKNOWN = 3'd2;
    localparam logic [2:0] KIND_OVERRUN = 3'd3;
    localparam logic [2:0] KIND_BAD_LEN = 3'd4;

    typedef struct packed {
        logic       is_cr;
        logic       is_bell;
        logic       is_ignore;
        logic       is_start;
        logic       start_ext;
        logic       start_rtr;
        logic       hex_ok;
        logic [3:0] nibble;
        logic [3:0] len_val;
    } cls_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] frame_id;
        logic        is_extended;
        logic        is_remote;
        logic [3:0]  data_length;
        logic [63:0] payload;
        logic [15:0] stamp;
    } res_t;

endpackage

### rtl/core/slcan_classify.sv
// Front part of the SLCAN parser: sorts one received character into classes.
// Depends on slcan_pkg for the class record and character codes.
`timescale 1ns / 1ps

module slcan_classify
    import slcan_pkg::*;
(
    input  logic [7:0] rx_byte,
    output cls_t       cls
);

    always_comb
    begin
        cls = '0;
        cls.is_cr = (rx_byte == CHAR_CR);
        cls.is_bell = (rx_byte == CHAR_BELL);
        cls.is_ignore = (rx_byte == 8'h7a) || (rx_byte == 8'h5a);
        cls.start_ext = (rx_byte == 8'h54) || (rx_byte == 8'h52);
        cls.start_rtr = (rx_byte == 8'h72) || (rx_byte == 8'h52);
        cls.is_start = (rx_byte == 8'h74) || cls.start_ext || (rx_byte == 8'h72);
        if (rx_byte >= 8'h30 && rx_byte <= 8'h39)
        begin
            cls.hex_ok = 1'b1;
            cls.nibble = rx_byte[3:0];
        end
        else if ((rx_byte >= 8'h61 && rx_byte <= 8'h66) ||
                 (rx_byte >= 8'h41 && rx_byte <= 8'h46))
        begin
            cls.hex_ok = 1'b1;
            cls.nibble = rx_byte[3:0] + 4'd9;
        end
        if (rx_byte >= 8'h30 && rx_byte <= 8'h38)
        begin
            cls.len_val = rx_byte[3:0];
        end
        else
        begin
            cls.len_val = BAD_LEN;
        end
    end

endmodule

### rtl/core/slcan_queue.sv
// Small first-word-fall-through queue used for the character and result queues of the parser.
// Generic; no package dependency.
`timescale 1ns / 1ps

module slcan_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/core/slcan_decode.sv
// Back part of the SLCAN parser: assembles identifier, length, data and
// timestamp from classified characters and forms one result per frame, bell, unknown character or overrun.
// Depends on slcan_pkg for the class and result records.
`timescale 1ns / 1ps

module slcan_decode
    import slcan_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 80
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_empty,
    input  cls_t in_cls,
    output logic in_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res
);

    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

    logic          in_frame_reg, in_frame_next;
    logic          ext_reg, ext_next;
    logic          rtr_reg, rtr_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [31:0]   id_reg, id_next;
    logic [3:0]    len_reg, len_next;
    logic [63:0]   data_reg, data_next;
    logic [15:0]   stamp_reg, stamp_next;
    logic          ended_reg, ended_next;

    logic          step;
    logic [PW-1:0] lenpos;
    logic [PW-1:0] rel;
    logic [PW-1:0] dchars;
    logic [2:0]    bidx;
    logic [7:0]    cur_b;
    logic          field_start;
    logic          eff_ended;

    assign step = !in_empty && !res_full;
    assign in_pop = step;

    always_comb
    begin
        lenpos = ext_reg ? PW'(1 + EXT_ID_DIGITS) : PW'(1 + STD_ID_DIGITS);
        rel = pos_reg - lenpos - 1'b1;
        dchars = rtr_reg ? '0 : PW'({len_reg, 1'b0});
        bidx = rel[3:1];
        cur_b = data_reg[bidx*8 +: 8];
        field_start = 1'b0;
        if (pos_reg < lenpos)
        begin
            field_start = (pos_reg == PW'(1));
        end
        else if (rel < dchars)
        begin
            field_start = !rel[0];
        end
        else
        begin
            field_start = (rel == dchars);
        end
        eff_ended = ended_reg && !field_start;
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        ext_next = ext_reg;
        rtr_next = rtr_reg;
        pos_next = pos_reg;
        id_next = id_reg;
        len_next = len_reg;
        data_next = data_reg;
        stamp_next = stamp_reg;
        ended_next = ended_reg;
        res_push = 1'b0;
        res = '0;
        if (step)
        begin
            if (!in_frame_reg)
            begin
                if (in_cls.is_bell)
                begin
                    res_push = 1'b1;
                    res.kind = KIND_BELL;
                end
                else if (in_cls.is_cr || in_cls.is_ignore)
                begin
                    res_push = 1'b0;
                end
                else if (in_cls.is_start)
                begin
                    in_frame_next = 1'b1;
                    ext_next = in_cls.start_ext;
                    rtr_next = in_cls.start_rtr;
                    pos_next = PW'(1);
                    id_next = '0;
                    len_next = BAD_LEN;
                    data_next = '0;
                    stamp_next = '0;
                    ended_next = 1'b0;
                end
                else
                begin
                    res_push = 1'b1;
                    res.kind = KIND_UNKNOWN;
                end
            end
            else if (pos_reg >= PW'(MAX_FRAME_BYTES))
            begin
                in_frame_next = 1'b0;
                res_push = 1'b1;
                res.kind = KIND_OVERRUN;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (in_cls.is_cr)
                begin
                    in_frame_next = 1'b0;
                    res_push = 1'b1;
                    if (len_reg > MAX_LEN)
                    begin
                        res.kind = KIND_BAD_LEN;
                    end
                    else
                    begin
                        res.kind = KIND_FRAME;
                        res.frame_id = id_reg;
                        res.is_extended = ext_reg;
                        res.is_remote = rtr_reg;
                        res.data_length = len_reg;
                        res.payload = rtr_reg ? '0 : data_reg;
                        res.stamp = stamp_reg;
                    end
                end
                else if (pos_reg == lenpos)
                begin
                    len_next = in_cls.len_val;
                end
                else if (pos_reg < lenpos || (len_reg <= MAX_LEN && rel < dchars + PW'(4)))
                begin
                    ended_next = eff_ended || !in_cls.hex_ok;
                    if (in_cls.hex_ok && !eff_ended)
                    begin
                        if (pos_reg < lenpos)
                        begin
                            id_next = {id_reg[27:0], in_cls.nibble};
                        end
                        else if (rel < dchars)
                        begin
                            data_next[bidx*8 +: 8] = {cur_b[3:0], in_cls.nibble};
                        end
                        else
                        begin
                            stamp_next = {stamp_reg[11:0], in_cls.nibble};
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            ext_reg <= 1'b0;
            rtr_reg <= 1'b0;
            pos_reg <= '0;
            id_reg <= '0;
            len_reg <= '0;
            data_reg <= '0;
            stamp_reg <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            ext_reg <= ext_next;
            rtr_reg <= rtr_next;
            pos_reg <= pos_next;
            id_reg <= id_next;
            len_reg <= len_next;
            data_reg <= data_next;
            stamp_reg <= stamp_next;
            ended_reg <= ended_next;
        end
    end

endmodule

### rtl/core/slcan_ascii_frame_parser.sv
// Top level of the SLCAN ASCII frame parser: classifier, character queue,
// decoder and result queue. Depends on slcan_pkg, slcan_classify, slcan_queue and slcan_decode.
// Path: a closing byte passes the character queue, the decoder and the result queue before its result is visible.
// Throughput: one byte per cycle while the result queue is not full; the decoder stalls while it is.
// Reset: asynchronous active-low reset clears both queues and all parser state.
`timescale 1ns / 1ps

module slcan_ascii_frame_parser
    import slcan_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 80
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  kind,
    output logic [31:0] frame_id,
    output logic        is_extended,
    output logic        is_remote,
    output logic [3:0]  data_length,
    output logic [63:0] payload,
    output logic [15:0] stamp
);

    cls_t cls_in;
    cls_t cls_q;
    logic cls_empty;
    logic cls_pop;
    logic res_full;
    logic res_push;
    res_t res_in;
    res_t res_q;

    slcan_classify u_classify (
        .rx_byte (rx_byte),
        .cls     (cls_in)
    );

    slcan_queue #(
        .WIDTH ($bits(cls_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cls_in),
        .full    (full),
        .pop     (cls_pop),
        .rd_data (cls_q),
        .empty   (cls_empty)
    );

    slcan_decode #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_empty (cls_empty),
        .in_cls   (cls_q),
        .in_pop   (cls_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_in)
    );

    slcan_queue #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_q),
        .empty   (empty)
    );

    assign kind = res_q.kind;
    assign frame_id = res_q.frame_id;
    assign is_extended = res_q.is_extended;
    assign is_remote = res_q.is_remote;
    assign data_length = res_q.data_length;
    assign payload = res_q.payload;
    assign stamp = res_q.stamp;

endmodule

### rtl/core/slcan_checker.sv
// Port-level checks for the SLCAN ASCII frame parser, bound to its top level.
// Depends on slcan_pkg for the result kinds.
`timescale 1ns / 1ps

module slcan_checker
    import slcan_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  kind,
    input logic [31:0] frame_id,
    input logic        is_extended,
    input logic        is_remote,
    input logic [3:0]  data_length,
    input logic [63:0] payload,
    input logic [15:0] stamp
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(frame_id) &&
                              $stable(payload) && $stable(stamp)))
        else $error("Waiting result changed before its transfer.");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (kind <= KIND_BAD_LEN))
        else $error("Result kind out of range.");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind != KIND_FRAME) |-> (frame_id == '0 && !is_extended &&
            !is_remote && data_length == '0 && payload == '0 && stamp == '0))
        else $error("Report result carries frame fields.");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_FRAME) |-> (data_length <= MAX_LEN))
        else $error("Frame with length above eight.");

    a_remote: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_FRAME && is_remote) |-> (payload == '0))
        else $error("Remote frame carries data.");

endmodule

bind slcan_ascii_frame_parser slcan_checker u_checker (.*);
